>>> design/ms_pkg.sv
// Shared types and constants for the merge sorter.
// No dependencies; every other file of the block but ms_ram uses this package.
`timescale 1ns / 1ps
`default_nettype none
package ms_pkg;

    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_item;
    } item_t;

endpackage
`default_nettype wire

>>> design/ms_in_if.sv
// Input channel of the merge sorter: valid/ready handshake with one value per beat.
// Depends on ms_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none
interface ms_in_if;

    logic                             valid;
    logic                             ready;
    logic signed [ms_pkg::DATA_W-1:0] value;
    logic                             last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);

endinterface
`default_nettype wire

>>> design/ms_out_if.sv
// Output channel of the merge sorter: valid/ready handshake with one sorted value per beat.
// Depends on ms_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none
interface ms_out_if;

    logic                             valid;
    logic                             ready;
    logic signed [ms_pkg::DATA_W-1:0] sorted_value;
    logic                             last_result;

    modport source (output valid, output sorted_value, output last_result, input ready);
    modport sink   (input valid, input sorted_value, input last_result, output ready);

endinterface
`default_nettype wire

>>> design/ms_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

>>> design/ms_front.sv
// Front end: accepts input beats and holds them in a short queue for the sort engine.
// Depends on ms_pkg and ms_in_if.
`timescale 1ns / 1ps
`default_nettype none
module ms_front (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ms_in_if.sink      items,
    output logic       q_valid,
    output ms_pkg::item_t q_item,
    input  wire logic  q_ready
);

    localparam int PW = ms_pkg::QUEUE_PTR_W;

    ms_pkg::item_t slot_reg [ms_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   fill_reg;
    logic [PW:0]   fill_next;
    logic          push;
    logic          pop;

    assign items.ready = (fill_reg != (PW+1)'(ms_pkg::QUEUE_DEPTH));
    assign q_valid     = (fill_reg != '0);
    assign q_item      = slot_reg[rd_ptr_reg];
    assign push        = items.valid && items.ready;
    assign pop         = q_valid && q_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].value     <= items.value;
            slot_reg[wr_ptr_reg].last_item <= items.last_item;
        end
    end

endmodule
`default_nettype wire

>>> design/ms_back.sv
// Back end: loads queued values into a RAM bank, runs bottom-up merge passes between
// two banks and emits the sorted set. Depends on ms_pkg, ms_ram and ms_out_if.
`timescale 1ns / 1ps
`default_nettype none
module ms_back #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire ms_pkg::item_t q_item,
    output logic               q_ready,
    ms_out_if.source           results
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = CNT_W + 2;
    localparam int DW    = ms_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_MERGE_RD,
        S_MERGE_WR,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [SUM_W-1:0]  width_reg;
    logic [SUM_W-1:0]  lo_reg;
    logic [SUM_W-1:0]  mid_reg;
    logic [SUM_W-1:0]  hi_reg;
    logic [SUM_W-1:0]  a_reg;
    logic [SUM_W-1:0]  b_reg;
    logic [SUM_W-1:0]  k_reg;
    logic              src_reg;
    logic [DW-1:0]     sorted_value_reg;
    logic              last_result_reg;
    logic              out_valid_reg;

    logic [DW-1:0]     b0_rdata_a;
    logic [DW-1:0]     b0_rdata_b;
    logic [DW-1:0]     b1_rdata_a;
    logic [DW-1:0]     b1_rdata_b;
    logic [DW-1:0]     rd_a;
    logic [DW-1:0]     rd_b;
    logic              we0;
    logic              we1;
    logic [IDX_W-1:0]  waddr;
    logic [DW-1:0]     wdata;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;

    logic [SUM_W-1:0]  n_ext;
    logic              a_ok;
    logic              b_ok;
    logic              take_a;
    logic [DW-1:0]     merge_data;
    logic [SUM_W-1:0]  k_inc;
    logic              seg_done;
    logic [SUM_W-1:0]  width_dbl;
    logic [SUM_W-1:0]  lo_step;
    logic              pass_done;
    logic              sort_done;
    logic [SUM_W-1:0]  seg_lo;
    logic [SUM_W-1:0]  seg_w;
    logic [SUM_W-1:0]  seg_mid_raw;
    logic [SUM_W-1:0]  seg_hi_raw;
    logic [SUM_W-1:0]  seg_mid;
    logic [SUM_W-1:0]  seg_hi;
    logic              load_fits;
    logic [CNT_W-1:0]  count_after;
    logic              pop;

    assign q_ready              = (state_reg == S_LOAD);
    assign pop                  = q_valid && q_ready;
    assign results.valid        = out_valid_reg;
    assign results.sorted_value = sorted_value_reg;
    assign results.last_result  = last_result_reg;

    assign n_ext      = SUM_W'(n_reg);
    assign rd_a       = src_reg ? b1_rdata_a : b0_rdata_a;
    assign rd_b       = src_reg ? b1_rdata_b : b0_rdata_b;
    assign a_ok       = (a_reg < mid_reg);
    assign b_ok       = (b_reg < hi_reg);
    assign take_a     = a_ok && (!b_ok || ($signed(rd_a) < $signed(rd_b)));
    assign merge_data = take_a ? rd_a : rd_b;
    assign k_inc      = k_reg + 1'b1;
    assign seg_done   = (k_inc == hi_reg);
    assign width_dbl  = width_reg << 1;
    assign lo_step    = lo_reg + width_dbl;
    assign pass_done  = (lo_step >= n_ext);
    assign sort_done  = (width_dbl >= n_ext);
    assign seg_lo     = pass_done ? '0 : lo_step;
    assign seg_w      = pass_done ? width_dbl : width_reg;
    assign seg_mid_raw = seg_lo + seg_w;
    assign seg_hi_raw  = seg_lo + (seg_w << 1);
    assign seg_mid    = (seg_mid_raw < n_ext) ? seg_mid_raw : n_ext;
    assign seg_hi     = (seg_hi_raw < n_ext) ? seg_hi_raw : n_ext;

    assign load_fits   = (count_reg < CNT_W'(MAX_ITEMS));
    assign count_after = count_reg + CNT_W'(load_fits);

    always_comb
    begin
        we0     = 1'b0;
        we1     = 1'b0;
        waddr   = k_reg[IDX_W-1:0];
        wdata   = merge_data;
        raddr_a = a_reg[IDX_W-1:0];
        raddr_b = b_reg[IDX_W-1:0];
        case (state_reg)
            S_LOAD:
            begin
                we0   = pop && load_fits;
                waddr = count_reg[IDX_W-1:0];
                wdata = q_item.value;
            end
            S_MERGE_WR:
            begin
                we0 = src_reg;
                we1 = !src_reg;
            end
            S_OUT_RD, S_OUT_LD, S_OUT_WAIT:
            begin
                raddr_a = k_reg[IDX_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    ms_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_bank0 (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (b0_rdata_a),
        .rdata_b (b0_rdata_b)
    );

    ms_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_bank1 (
        .clk     (clk),
        .we      (we1),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (b1_rdata_a),
        .rdata_b (b1_rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            n_reg            <= '0;
            width_reg        <= '0;
            lo_reg           <= '0;
            mid_reg          <= '0;
            hi_reg           <= '0;
            a_reg            <= '0;
            b_reg            <= '0;
            k_reg            <= '0;
            src_reg          <= 1'b0;
            sorted_value_reg <= '0;
            last_result_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (pop)
                    begin
                        count_reg <= count_after;
                        if (q_item.last_item)
                        begin
                            n_reg   <= count_after;
                            src_reg <= 1'b0;
                            k_reg   <= '0;
                            if (count_after >= CNT_W'(2))
                            begin
                                width_reg <= SUM_W'(1);
                                lo_reg    <= '0;
                                mid_reg   <= SUM_W'(1);
                                hi_reg    <= SUM_W'(2);
                                a_reg     <= '0;
                                b_reg     <= SUM_W'(1);
                                state_reg <= S_MERGE_RD;
                            end
                            else
                            begin
                                state_reg <= S_OUT_RD;
                            end
                        end
                    end
                end
                S_MERGE_RD:
                begin
                    state_reg <= S_MERGE_WR;
                end
                S_MERGE_WR:
                begin
                    // advance the head that was taken
                    a_reg <= a_reg + SUM_W'(take_a);
                    b_reg <= b_reg + SUM_W'(!take_a);
                    k_reg <= k_inc;
                    state_reg <= S_MERGE_RD;
                    if (seg_done)
                    begin
                        lo_reg    <= seg_lo;
                        width_reg <= seg_w;
                        mid_reg   <= seg_mid;
                        hi_reg    <= seg_hi;
                        a_reg     <= seg_lo;
                        b_reg     <= seg_mid;
                        k_reg     <= seg_lo;
                        if (pass_done)
                        begin
                            src_reg <= !src_reg;
                            if (sort_done)
                            begin
                                k_reg     <= '0;
                                state_reg <= S_OUT_RD;
                            end
                        end
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_LD;
                end
                S_OUT_LD:
                begin
                    sorted_value_reg <= rd_a;
                    last_result_reg  <= (k_inc == n_ext);
                    out_valid_reg    <= 1'b1;
                    state_reg        <= S_OUT_WAIT;
                end
                S_OUT_WAIT:
                begin
                    if (results.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_result_reg)
                        begin
                            count_reg <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_inc;
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> design/merge_sorter.sv
// Merge sorter: loads a set of signed values, sorts it ascending, emits it in order.
// Loading accepts one beat per cycle through the front-end queue while the back end loads;
// sorting runs ceil(log2 n) merge passes, each merged value taking a RAM read state and a
// write state; each result passes read, load and wait states, then waits for the sink.
// Reset clears the queue, the item count and the output valid; RAM contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module merge_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ms_in_if.sink     items,
    ms_out_if.source  results
);

    logic          q_valid;
    logic          q_ready;
    ms_pkg::item_t q_item;

    ms_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready)
    );

    ms_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready),
        .results (results)
    );

endmodule
`default_nettype wire
